[rtl/core/slpt_pkg.sv]
// ----------------------------------------------------------------------------
// slpt_pkg
// Shared types, constants and helper functions of the spectrum level tracker.
// ----------------------------------------------------------------------------
package slpt_pkg;

  localparam int unsigned ChanW          = 7;
  localparam int unsigned LevelW         = 7;
  localparam int unsigned TimerW         = 8;
  localparam int unsigned NumChannelsDef = 126;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned CfgIdxW        = 8;
  localparam int unsigned CfgDataW       = 8;
  localparam int unsigned SweepW         = 32;

  localparam logic [LevelW-1:0] LevelMax = LevelW'(100);
  localparam logic [LevelW-1:0] CountMax = LevelW'(127);

  typedef enum logic [CfgIdxW-1:0] {
    CfgPeakHold  = 8'd0,
    CfgLabelHold = 8'd1,
    CfgDecayStep = 8'd2,
    CfgActThresh = 8'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BandNone    = 3'd0,
    BandWifi    = 3'd1,
    BandBle     = 3'd2,
    BandClassic = 3'd3,
    BandZigbee  = 3'd4
  } band_e;

  typedef struct packed {
    logic [ChanW-1:0] chan_index;
    logic             power_hit;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [LevelW-1:0] peak;
    logic [2:0]        intensity_class;
    logic              label_shown;
    logic [2:0]        band_kind;
    logic              sweep_done;
    logic [LevelW-1:0] max_level;
    logic [ChanW-1:0]  max_channel;
    logic [LevelW-1:0] active_channels;
    logic [SweepW-1:0] sweep_total;
  } out_item_t;

  typedef struct packed {
    logic [TimerW-1:0] peak_hold;
    logic [TimerW-1:0] label_hold;
    logic [LevelW-1:0] decay_step;
    logic [LevelW-1:0] act_thresh;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] chan_index;
    logic             power_hit;
    logic             in_range;
    logic             last;
    band_e            band;
  } work_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [LevelW-1:0] peak;
    logic [TimerW-1:0] peak_timer;
    logic [TimerW-1:0] label_timer;
  } entry_t;

  function automatic logic [2:0] intensity_of(logic [LevelW-1:0] lv);
    logic [2:0] cls;
    if (lv > LevelW'(85)) cls = 3'd4;
    else if (lv > LevelW'(65)) cls = 3'd3;
    else if (lv > LevelW'(45)) cls = 3'd2;
    else if (lv > LevelW'(25)) cls = 3'd1;
    else cls = 3'd0;
    return cls;
  endfunction

  // Wifi covers 12..84, so classic bt never wins and only 5 and 10 stay zigbee.
  function automatic band_e band_of(logic [ChanW-1:0] ch);
    band_e b;
    if (ch >= ChanW'(12) && ch <= ChanW'(84)) b = BandWifi;
    else if (ch == ChanW'(2)) b = BandBle;
    else if (ch == ChanW'(5) || ch == ChanW'(10)) b = BandZigbee;
    else b = BandNone;
    return b;
  endfunction

endpackage

[rtl/core/slpt_fifo.sv]
// ----------------------------------------------------------------------------
// slpt_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module slpt_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = slpt_pkg::QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

[rtl/core/slpt_front.sv]
// ----------------------------------------------------------------------------
// slpt_front
// Accepts samples, classifies channel range, sweep end and band, and queues
// them for the update stage.
// ----------------------------------------------------------------------------
module slpt_front #(
  parameter int unsigned NumChannels = slpt_pkg::NumChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  slpt_pkg::in_item_t in_item_i,
  input  logic               q_pop_i,
  output slpt_pkg::work_t    q_data_o,
  output logic               q_empty_o
);

  slpt_pkg::work_t cls;

  always_comb begin
    cls.chan_index = in_item_i.chan_index;
    cls.power_hit  = in_item_i.power_hit;
    cls.in_range   = ({1'b0, in_item_i.chan_index} < (slpt_pkg::ChanW + 1)'(NumChannels));
    cls.last       = (in_item_i.chan_index == slpt_pkg::ChanW'(NumChannels - 1));
    cls.band       = slpt_pkg::band_of(in_item_i.chan_index);
  end

  slpt_fifo #(
    .T     (slpt_pkg::work_t),
    .Depth (slpt_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls),
    .full_o  (full),
    .pop_i   (q_pop_i),
    .data_o  (q_data_o),
    .empty_o (q_empty_o)
  );

endmodule

[rtl/core/slpt_back.sv]
// ----------------------------------------------------------------------------
// slpt_back
// Per-channel read-modify-write of level, peak and timers, sweep statistics
// and the result queue.
// ----------------------------------------------------------------------------
module slpt_back #(
  parameter int unsigned NumChannels = slpt_pkg::NumChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slpt_pkg::cfg_t      cfg_i,
  input  slpt_pkg::work_t     q_data_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                empty,
  input  logic                pop,
  output slpt_pkg::out_item_t out_item_o
);

  localparam int unsigned IdxW   = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int unsigned LevelW = slpt_pkg::LevelW;
  localparam int unsigned TimerW = slpt_pkg::TimerW;
  localparam int unsigned ChanW  = slpt_pkg::ChanW;

  slpt_pkg::entry_t mem_q [NumChannels];
  slpt_pkg::entry_t rd_q;
  slpt_pkg::entry_t byp_q;
  logic [IdxW-1:0]  byp_idx_q;
  logic             byp_vld_q;
  logic [NumChannels-1:0] vld_q;

  logic            e_vld_q;
  slpt_pkg::work_t e_q;

  logic [LevelW-1:0]          run_max_q, run_ch_q, run_cnt_q;
  logic [slpt_pkg::SweepW-1:0] sweep_q, sweep_d;

  logic                oq_full, e_fire, adv;
  logic [IdxW-1:0]     rd_idx, e_idx;
  slpt_pkg::entry_t    cur, nxt;
  logic [LevelW:0]     half_sum;
  logic [LevelW+1:0]   scaled;
  logic [LevelW-1:0]   lv;
  logic [LevelW-1:0]   base_max, base_ch, base_cnt;
  logic [LevelW-1:0]   new_max, new_ch, new_cnt;
  slpt_pkg::out_item_t res;

  assign e_fire  = e_vld_q && !oq_full;
  assign adv     = !q_empty_i && (!e_vld_q || e_fire);
  assign q_pop_o = adv;
  assign rd_idx  = q_data_i.chan_index[IdxW-1:0];
  assign e_idx   = e_q.chan_index[IdxW-1:0];

  always_comb begin
    if (!e_q.in_range) cur = '0;
    else if (byp_vld_q && byp_idx_q == e_idx) cur = byp_q;
    else if (vld_q[e_idx]) cur = rd_q;
    else cur = '0;

    half_sum = {1'b0, cur.level} + (LevelW + 1)'(slpt_pkg::LevelMax);
    scaled   = {2'b00, cur.level} + {1'b0, cur.level, 1'b0};
    nxt      = cur;
    if (e_q.power_hit) begin
      lv = (half_sum[LevelW:1] > slpt_pkg::LevelMax) ? slpt_pkg::LevelMax
                                                      : half_sum[LevelW:1];
      nxt.label_timer = cfg_i.label_hold;
    end else begin
      lv = scaled[LevelW+1:2];
      if (cur.label_timer != '0) nxt.label_timer = cur.label_timer - TimerW'(1);
    end
    nxt.level = lv;

    if (lv >= cur.peak) begin
      nxt.peak       = lv;
      nxt.peak_timer = cfg_i.peak_hold;
    end else if (cur.peak_timer != '0) begin
      nxt.peak_timer = cur.peak_timer - TimerW'(1);
    end else begin
      nxt.peak = (cur.peak > cfg_i.decay_step) ? cur.peak - cfg_i.decay_step : '0;
    end

    if (e_q.chan_index == '0) begin
      base_max = '0;
      base_ch  = '0;
      base_cnt = '0;
    end else begin
      base_max = run_max_q;
      base_ch  = run_ch_q;
      base_cnt = run_cnt_q;
    end
    new_max = (lv > base_max) ? lv : base_max;
    new_ch  = (lv > base_max) ? e_q.chan_index : base_ch;
    new_cnt = (lv > cfg_i.act_thresh && base_cnt != slpt_pkg::CountMax)
            ? base_cnt + LevelW'(1) : base_cnt;

    sweep_d = (e_q.in_range && e_q.last) ? sweep_q + 32'd1 : sweep_q;

    res             = '0;
    res.sweep_total = sweep_d;
    if (e_q.in_range) begin
      res.level           = lv;
      res.peak            = nxt.peak;
      res.intensity_class = slpt_pkg::intensity_of(lv);
      res.label_shown     = (lv > cfg_i.act_thresh) || (nxt.label_timer != '0);
      res.band_kind       = e_q.band;
      if (e_q.last) begin
        res.sweep_done      = 1'b1;
        res.max_level       = new_max;
        res.max_channel     = ChanW'(new_ch);
        res.active_channels = new_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q   <= 1'b0;
      byp_vld_q <= 1'b0;
      vld_q     <= '0;
      run_max_q <= '0;
      run_ch_q  <= '0;
      run_cnt_q <= '0;
      sweep_q   <= '0;
    end else begin
      if (adv) e_vld_q <= 1'b1;
      else if (e_fire) e_vld_q <= 1'b0;
      if (e_fire) begin
        sweep_q <= sweep_d;
        if (e_q.in_range) begin
          byp_vld_q    <= 1'b1;
          vld_q[e_idx] <= 1'b1;
          if (e_q.last) begin
            run_max_q <= '0;
            run_ch_q  <= '0;
            run_cnt_q <= '0;
          end else begin
            run_max_q <= new_max;
            run_ch_q  <= new_ch;
            run_cnt_q <= new_cnt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) e_q <= q_data_i;
    if (adv && q_data_i.in_range) rd_q <= mem_q[rd_idx];
    if (e_fire && e_q.in_range) begin
      mem_q[e_idx] <= nxt;
      byp_q        <= nxt;
      byp_idx_q    <= e_idx;
    end
  end

  slpt_fifo #(
    .T     (slpt_pkg::out_item_t),
    .Depth (slpt_pkg::QueueDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (e_fire),
    .data_i  (res),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

[rtl/core/spectrum_level_peak_tracker_core.sv]
// ----------------------------------------------------------------------------
// spectrum_level_peak_tracker_core
// Per-channel smoothed level and peak hold tracker with sweep statistics.
// ----------------------------------------------------------------------------
// One sample is taken and one result comes out per cycle when the result side
// is not stalled. The rate is set by the single read-modify-write of the
// channel store: the read is issued as an item leaves the input queue and the
// write as it leaves the update register, with a bypass of the last written
// entry for back-to-back samples of the same channel. Channel state starts at
// zero from per-channel valid bits, so the block is ready right after reset.
// Configuration must be written through the cfg port while the block is idle;
// the block does not enforce this. Writes to unknown indexes are dropped.
module spectrum_level_peak_tracker_core #(
  parameter int unsigned NumChannels = slpt_pkg::NumChannelsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  slpt_pkg::in_item_t              in_item_i,
  output logic                            empty,
  input  logic                            pop,
  output slpt_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [slpt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [slpt_pkg::CfgDataW-1:0]   cfg_data_i
);

  slpt_pkg::cfg_t  cfg_q;
  slpt_pkg::work_t q_data;
  logic            q_empty, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_hold  <= slpt_pkg::TimerW'(25);
      cfg_q.label_hold <= slpt_pkg::TimerW'(10);
      cfg_q.decay_step <= slpt_pkg::LevelW'(2);
      cfg_q.act_thresh <= slpt_pkg::LevelW'(10);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        slpt_pkg::CfgPeakHold:  cfg_q.peak_hold  <= cfg_data_i;
        slpt_pkg::CfgLabelHold: cfg_q.label_hold <= cfg_data_i;
        slpt_pkg::CfgDecayStep: cfg_q.decay_step <= cfg_data_i[slpt_pkg::LevelW-1:0];
        slpt_pkg::CfgActThresh: cfg_q.act_thresh <= cfg_data_i[slpt_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  slpt_front #(
    .NumChannels (NumChannels)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .q_pop_i   (q_pop),
    .q_data_o  (q_data),
    .q_empty_o (q_empty)
  );

  slpt_back #(
    .NumChannels (NumChannels)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_data_i   (q_data),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

[tb/sv/tb_spectrum_level_peak_tracker_core.sv]
// ----------------------------------------------------------------------------
// tb_spectrum_level_peak_tracker_core
// Self-checking bench for the per-channel level and peak hold tracker. Samples
// go in through the push/full queue port, reports come out through empty/pop,
// and every report is compared field by field with a local model of the
// channel stores, the sweep statistics and the configuration registers.
// Directed cases cover the field extremes, out-of-range indexes, band edges,
// peak decay and ties. Random sweeps, noise, a saturating sweep and a long
// output stall follow, under several register settings.
// ----------------------------------------------------------------------------
module tb_spectrum_level_peak_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import slpt_pkg::*;

  localparam int unsigned NumCh      = NumChannelsDef;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned StallLen   = 300;
  localparam int unsigned Latency    = 3;

  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 8'hFF;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  in_item_t            in_item;
  logic                empty;
  logic                pop;
  out_item_t           out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  logic                stall_go;
  logic                idle_en;
  int                  err_cnt;
  int                  cycle_cnt;

  // local copy of the block state
  logic [LevelW-1:0]   level_mem [NumCh];
  logic [LevelW-1:0]   peak_mem  [NumCh];
  logic [TimerW-1:0]   peak_tmr  [NumCh];
  logic [TimerW-1:0]   label_tmr [NumCh];
  logic [LevelW-1:0]   sweep_max_level;
  logic [ChanW-1:0]    sweep_max_chan;
  logic [LevelW-1:0]   sweep_active;
  logic [SweepW-1:0]   sweep_cnt;
  logic [TimerW-1:0]   peak_hold;
  logic [TimerW-1:0]   label_hold;
  logic [LevelW-1:0]   decay_step;
  logic [LevelW-1:0]   act_thresh;

  out_item_t           expected_reports_q [$];

  spectrum_level_peak_tracker_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_spectrum_level_peak_tracker_core failed");
    $finish;
  end

  function automatic logic [2:0] grade_level(input int lv);
    if (lv > 85) return 3'd4;
    if (lv > 65) return 3'd3;
    if (lv > 45) return 3'd2;
    if (lv > 25) return 3'd1;
    return 3'd0;
  endfunction

  function automatic band_e band_for(input int ch);
    if (ch >= 12 && ch <= 84) return BandWifi;
    if (ch == 2 || ch == 26 || ch == 80) return BandBle;
    if (ch >= 50 && ch <= 79) return BandClassic;
    if (ch >= 5 && ch <= 80 && (ch - 5) % 5 == 0) return BandZigbee;
    return BandNone;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("[cycle %0d] mismatch: %s", cycle_cnt, msg);
  endtask

  task automatic clear_tracker();
    for (int i = 0; i < NumCh; i++) begin
      level_mem[i] = '0;
      peak_mem[i]  = '0;
      peak_tmr[i]  = '0;
      label_tmr[i] = '0;
    end
    sweep_max_level = '0;
    sweep_max_chan  = '0;
    sweep_active    = '0;
    sweep_cnt       = '0;
    peak_hold       = 8'd25;
    label_hold      = 8'd10;
    decay_step      = 7'd2;
    act_thresh      = 7'd10;
  endtask

  task automatic track_sample(input logic [ChanW-1:0] ch, input logic hit);
    out_item_t r;
    int        lv;
    int        pk;
    r = '0;
    if (ch >= NumCh) begin
      r.sweep_total = sweep_cnt;
      expected_reports_q.push_back(r);
      return;
    end
    lv = level_mem[ch];
    if (hit) begin
      lv = (lv + 100) / 2;
      if (lv > 100) lv = 100;
      label_tmr[ch] = label_hold;
    end else begin
      lv = (lv * 3) / 4;
      if (label_tmr[ch] != 0) label_tmr[ch]--;
    end
    level_mem[ch] = LevelW'(lv);

    pk = peak_mem[ch];
    if (lv >= pk) begin
      pk = lv;
      peak_tmr[ch] = peak_hold;
    end else if (peak_tmr[ch] != 0) begin
      peak_tmr[ch]--;
    end else begin
      pk = (pk > int'(decay_step)) ? pk - int'(decay_step) : 0;
    end
    peak_mem[ch] = LevelW'(pk);

    if (ch == 0) begin
      sweep_max_level = '0;
      sweep_max_chan  = '0;
      sweep_active    = '0;
    end
    if (lv > int'(sweep_max_level)) begin
      sweep_max_level = LevelW'(lv);
      sweep_max_chan  = ch;
    end
    if (lv > int'(act_thresh) && sweep_active < CountMax) sweep_active++;

    r.level           = LevelW'(lv);
    r.peak            = LevelW'(pk);
    r.intensity_class = grade_level(lv);
    r.label_shown     = (lv > int'(act_thresh)) || (label_tmr[ch] != 0);
    r.band_kind       = band_for(ch);
    if (ch == NumCh - 1) begin
      sweep_cnt++;
      r.sweep_done      = 1'b1;
      r.max_level       = sweep_max_level;
      r.max_channel     = sweep_max_chan;
      r.active_channels = sweep_active;
      sweep_max_level   = '0;
      sweep_max_chan    = '0;
      sweep_active      = '0;
    end
    r.sweep_total = sweep_cnt;
    expected_reports_q.push_back(r);
  endtask

  // Call at a clock edge; returns at the edge of the transfer with push held.
  task automatic send_sample(input logic [ChanW-1:0] ch, input logic hit);
    while (idle_en && $urandom_range(99) < 16) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push               <= 1'b1;
    in_item.chan_index <= ch;
    in_item.power_hit  <= hit;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    track_sample(ch, hit);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_reports_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CfgPeakHold:  peak_hold  = data;
      CfgLabelHold: label_hold = data;
      CfgDecayStep: decay_step = data[LevelW-1:0];
      CfgActThresh: act_thresh = data[LevelW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int ph, input int lh, input int ds, input int at);
    drain();
    write_reg(CfgPeakHold, CfgDataW'(ph));
    write_reg(CfgLabelHold, CfgDataW'(lh));
    write_reg(CfgDecayStep, CfgDataW'(ds));
    write_reg(CfgActThresh, CfgDataW'(at));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_sample(7'd0, 1'b1);
    send_sample(7'd2, 1'b1);
    send_sample(7'd5, 1'b0);
    send_sample(7'd10, 1'b1);
    send_sample(7'd12, 1'b1);
    send_sample(7'd26, 1'b1);
    send_sample(7'd80, 1'b0);
    send_sample(7'd84, 1'b1);
    send_sample(7'd85, 1'b1);
    send_sample(7'd126, 1'b1);
    send_sample(7'd127, 1'b0);
    send_sample(7'd125, 1'b1);
  endtask

  task automatic test_peak_decay();
    apply_settings(0, 0, 100, 0);
    send_sample(7'd3, 1'b1);
    send_sample(7'd3, 1'b1);
    send_sample(7'd3, 1'b0);
    send_sample(7'd3, 1'b0);
    send_sample(7'd3, 1'b1);
    send_sample(7'd3, 1'b0);
  endtask

  task automatic test_unknown_reg();
    drain();
    write_reg(CfgUnusedLo, 8'hFF);
    write_reg(CfgUnusedHi, 8'h00);
    cfg_valid <= 1'b0;
    send_sample(7'd4, 1'b1);
    send_sample(7'd4, 1'b0);
  endtask

  task automatic test_strongest_tie();
    send_sample(7'd0, 1'b0);
    send_sample(7'd60, 1'b1);
    send_sample(7'd61, 1'b1);
    send_sample(7'd125, 1'b0);
  endtask

  task automatic test_active_saturation();
    apply_settings(25, 10, 2, 10);
    send_sample(7'd0, 1'b1);
    repeat (130) send_sample(7'($urandom_range(124, 1)), 1'b1);
    send_sample(7'd125, 1'b1);
  endtask

  task automatic test_output_stall();
    push     <= 1'b0;
    stall_go <= 1'b1;
    @(posedge clk_i);
    stall_go <= 1'b0;
    repeat (40) send_sample(7'($urandom_range(NumCh - 1)), 1'($urandom_range(1)));
  endtask

  task automatic test_random_sweeps(input int sweeps, input int hit_pct, input bit steady);
    int ch;
    if (steady) idle_en <= 1'b0;
    repeat (sweeps) begin
      ch = 0;
      while (ch < NumCh) begin
        if ($urandom_range(99) < 4) begin
          send_sample(7'($urandom_range(127)), 1'($urandom_range(1)));
        end else begin
          if ($urandom_range(99) >= 3) send_sample(7'(ch), $urandom_range(99) < hit_pct);
          ch++;
        end
      end
    end
    if (steady) idle_en <= 1'b1;
  endtask

  task automatic test_noise(input int count);
    repeat (count) send_sample(7'($urandom_range(127)), 1'($urandom_range(1)));
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_go) hold_left = StallLen;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (idle_en && $urandom_range(99) < 16) begin
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      got = out_item;
      if (expected_reports_q.size() == 0) begin
        report_mismatch($sformatf("result with no sample pending, level %0d", got.level));
      end else begin
        want = expected_reports_q.pop_front();
        if (got.level !== want.level)
          report_mismatch($sformatf("level got %0d want %0d", got.level, want.level));
        if (got.peak !== want.peak)
          report_mismatch($sformatf("peak got %0d want %0d", got.peak, want.peak));
        if (got.intensity_class !== want.intensity_class)
          report_mismatch($sformatf("intensity_class got %0d want %0d",
                                    got.intensity_class, want.intensity_class));
        if (got.label_shown !== want.label_shown)
          report_mismatch($sformatf("label_shown got %0d want %0d",
                                    got.label_shown, want.label_shown));
        if (got.band_kind !== want.band_kind)
          report_mismatch($sformatf("band_kind got %0d want %0d",
                                    got.band_kind, want.band_kind));
        if (got.sweep_done !== want.sweep_done)
          report_mismatch($sformatf("sweep_done got %0d want %0d",
                                    got.sweep_done, want.sweep_done));
        if (got.max_level !== want.max_level)
          report_mismatch($sformatf("max_level got %0d want %0d",
                                    got.max_level, want.max_level));
        if (got.max_channel !== want.max_channel)
          report_mismatch($sformatf("max_channel got %0d want %0d",
                                    got.max_channel, want.max_channel));
        if (got.active_channels !== want.active_channels)
          report_mismatch($sformatf("active_channels got %0d want %0d",
                                    got.active_channels, want.active_channels));
        if (got.sweep_total !== want.sweep_total)
          report_mismatch($sformatf("sweep_total got %0d want %0d",
                                    got.sweep_total, want.sweep_total));
      end
    end
  end

  initial begin
    err_cnt   = 0;
    cycle_cnt = 0;
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    stall_go  <= 1'b0;
    idle_en   <= 1'b1;
    clear_tracker();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_peak_decay();
    test_unknown_reg();
    test_strongest_tie();
    test_active_saturation();
    test_output_stall();

    apply_settings(0, 0, 0, 0);
    test_random_sweeps(1, 50, 1'b0);
    apply_settings(255, 255, 100, 100);
    test_random_sweeps(1, 60, 1'b1);
    apply_settings($urandom_range(255), $urandom_range(255),
                   $urandom_range(100), $urandom_range(100));
    test_random_sweeps(2, $urandom_range(90, 10), 1'b0);
    test_noise(100);
    apply_settings(3, 2, 100, 50);
    test_random_sweeps(1, 30, 1'b0);

    drain();
    repeat (Latency + 10) @(posedge clk_i);
    if (expected_reports_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_reports_q.size()));
    if (err_cnt == 0) begin
      $display("tb_spectrum_level_peak_tracker_core passed");
    end else begin
      $display("tb_spectrum_level_peak_tracker_core failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/slpt_pkg.sv
rtl/core/slpt_fifo.sv
rtl/core/slpt_front.sv
rtl/core/slpt_back.sv
rtl/core/spectrum_level_peak_tracker_core.sv
tb/sv/tb_spectrum_level_peak_tracker_core.sv
